@@ design/segment_intersection_core_macros.svh @@
// Assertion macros shared by the segment intersection core.
// No dependencies; the including module supplies aclk and aresetn.
`ifndef SEGMENT_INTERSECTION_CORE_MACROS_SVH
`define SEGMENT_INTERSECTION_CORE_MACROS_SVH

// checked only out of reset
`define SIC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked on every edge, reset included
`define SIC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

@@ design/sic_pkg.sv @@
// Shared types for the segment intersection core.
// No dependencies.
package sic_pkg;

    // per-beat flags carried alongside the divider payload
    typedef struct packed {
        logic qneg;   // ratio negative
        logic hit;    // both ratios within [0,1]
        logic zero;   // denominator zero
        logic ovf;    // quotient too wide for the divider
    } sic_flags_t;

endpackage

@@ design/sic_prep.sv @@
// Front end: differences, cross products, denominator and numerators, sign fix-up.
// Four register stages. Depends on sic_pkg.
module sic_prep #(
    parameter int C = 16,
    parameter int F = 16
) (
    input  logic                   aclk,
    input  logic                   en,
    input  logic signed [C-1:0]    ax,
    input  logic signed [C-1:0]    ay,
    input  logic signed [C-1:0]    bx,
    input  logic signed [C-1:0]    by,
    input  logic signed [C-1:0]    cx,
    input  logic signed [C-1:0]    cy,
    input  logic signed [C-1:0]    dx,
    input  logic signed [C-1:0]    dy,
    output logic signed [C-1:0]    ax_o,
    output logic signed [C-1:0]    ay_o,
    output logic signed [C:0]      bax_o,
    output logic signed [C:0]      bay_o,
    output logic [2*C+2:0]         den_o,
    output logic [2*C+3+F-1:0]     num_o,
    output sic_pkg::sic_flags_t    flags_o
);
    localparam int DI = C + 1;
    localparam int PR = 2 * C + 2;
    localparam int DW = 2 * C + 3;
    localparam int NW = DW + F;
    localparam int OW = DW + C + 2;

    // stage 1
    logic signed [C-1:0]  ax1_reg, ay1_reg;
    logic signed [DI-1:0] bax1_reg, bay1_reg, dcx1_reg, dcy1_reg, acx1_reg, acy1_reg;
    // stage 2
    logic signed [C-1:0]  ax2_reg, ay2_reg;
    logic signed [DI-1:0] bax2_reg, bay2_reg;
    logic signed [PR-1:0] p_dcy_bax_reg, p_dcx_bay_reg, p_dcx_acy_reg;
    logic signed [PR-1:0] p_dcy_acx_reg, p_bax_acy_reg, p_bay_acx_reg;
    // stage 3
    logic signed [C-1:0]  ax3_reg, ay3_reg;
    logic signed [DI-1:0] bax3_reg, bay3_reg;
    logic signed [DW-1:0] den3_reg, na3_reg, nb3_reg;
    // stage 4 logic
    logic signed [DW-1:0] den_n, na_n, nb_n;
    logic [DW-1:0]        nam;
    sic_pkg::sic_flags_t  flags_next;

    always_ff @(posedge aclk) begin
        if (en) begin
            ax1_reg  <= ax;
            ay1_reg  <= ay;
            bax1_reg <= DI'(bx) - DI'(ax);
            bay1_reg <= DI'(by) - DI'(ay);
            dcx1_reg <= DI'(dx) - DI'(cx);
            dcy1_reg <= DI'(dy) - DI'(cy);
            acx1_reg <= DI'(ax) - DI'(cx);
            acy1_reg <= DI'(ay) - DI'(cy);

            ax2_reg       <= ax1_reg;
            ay2_reg       <= ay1_reg;
            bax2_reg      <= bax1_reg;
            bay2_reg      <= bay1_reg;
            p_dcy_bax_reg <= dcy1_reg * bax1_reg;
            p_dcx_bay_reg <= dcx1_reg * bay1_reg;
            p_dcx_acy_reg <= dcx1_reg * acy1_reg;
            p_dcy_acx_reg <= dcy1_reg * acx1_reg;
            p_bax_acy_reg <= bax1_reg * acy1_reg;
            p_bay_acx_reg <= bay1_reg * acx1_reg;

            ax3_reg  <= ax2_reg;
            ay3_reg  <= ay2_reg;
            bax3_reg <= bax2_reg;
            bay3_reg <= bay2_reg;
            den3_reg <= DW'(p_dcy_bax_reg) - DW'(p_dcx_bay_reg);
            na3_reg  <= DW'(p_dcx_acy_reg) - DW'(p_dcy_acx_reg);
            nb3_reg  <= DW'(p_bax_acy_reg) - DW'(p_bay_acx_reg);

            ax_o    <= ax3_reg;
            ay_o    <= ay3_reg;
            bax_o   <= bax3_reg;
            bay_o   <= bay3_reg;
            den_o   <= den_n;
            num_o   <= {nam, {F{1'b0}}};
            flags_o <= flags_next;
        end
    end

    // make the denominator positive, numerators follow
    always_comb begin
        den_n = den3_reg[DW-1] ? -den3_reg : den3_reg;
        na_n  = den3_reg[DW-1] ? -na3_reg  : na3_reg;
        nb_n  = den3_reg[DW-1] ? -nb3_reg  : nb3_reg;
        nam   = na_n[DW-1] ? DW'(-na_n) : DW'(na_n);
        flags_next.qneg = na_n[DW-1];
        flags_next.hit  = !na_n[DW-1] && (na_n <= den_n) && !nb_n[DW-1] && (nb_n <= den_n);
        flags_next.zero = (den3_reg == '0);
        flags_next.ovf  = (OW'(nam) >= (OW'(den_n) << (C + 2)));
    end

endmodule

@@ design/sic_div.sv @@
// Restoring divider, one quotient bit per register stage.
// Carries coordinates and flags alongside. Depends on sic_pkg.
module sic_div #(
    parameter int C = 16,
    parameter int F = 16
) (
    input  logic                   aclk,
    input  logic                   en,
    input  logic signed [C-1:0]    ax,
    input  logic signed [C-1:0]    ay,
    input  logic signed [C:0]      bax,
    input  logic signed [C:0]      bay,
    input  logic [2*C+2:0]         den,
    input  logic [2*C+3+F-1:0]     num,
    input  sic_pkg::sic_flags_t    flags,
    output logic signed [C-1:0]    ax_o,
    output logic signed [C-1:0]    ay_o,
    output logic signed [C:0]      bax_o,
    output logic signed [C:0]      bay_o,
    output logic [C+1+F:0]         quo_o,
    output sic_pkg::sic_flags_t    flags_o
);
    localparam int DW = 2 * C + 3;
    localparam int NW = DW + F;
    localparam int QW = C + 2 + F;
    localparam int SW = 4 * C + 2;

    logic [NW-1:0]       rem_a [QW+1];
    logic [QW-1:0]       quo_a [QW+1];
    logic [DW-1:0]       den_a [QW+1];
    logic [SW-1:0]       side_a [QW+1];
    sic_pkg::sic_flags_t flg_a [QW+1];

    assign rem_a[0]  = num;
    assign quo_a[0]  = '0;
    assign den_a[0]  = den;
    assign side_a[0] = {bay, bax, ay, ax};
    assign flg_a[0]  = flags;

    for (genvar j = 0; j < QW; j++) begin : g_stage
        localparam int K = QW - 1 - j;
        logic ge;
        assign ge = (rem_a[j][NW-1:K] >= den_a[j]);
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_a[j+1]  <= ge ? rem_a[j] - (NW'(den_a[j]) << K) : rem_a[j];
                quo_a[j+1]  <= quo_a[j] | (QW'(ge) << K);
                den_a[j+1]  <= den_a[j];
                side_a[j+1] <= side_a[j];
                flg_a[j+1]  <= flg_a[j];
            end
        end
    end

    assign ax_o    = side_a[QW][C-1:0];
    assign ay_o    = side_a[QW][2*C-1:C];
    assign bax_o   = side_a[QW][3*C:2*C];
    assign bay_o   = side_a[QW][SW-1:3*C+1];
    assign quo_o   = quo_a[QW];
    assign flags_o = flg_a[QW];

endmodule

@@ design/sic_place.sv @@
// Back end: clamp the ratio, scale the first segment, round, offset and saturate.
// Three register stages. Depends on sic_pkg.
module sic_place #(
    parameter int C = 16,
    parameter int F = 16
) (
    input  logic                   aclk,
    input  logic                   en,
    input  logic signed [C-1:0]    ax,
    input  logic signed [C-1:0]    ay,
    input  logic signed [C:0]      bax,
    input  logic signed [C:0]      bay,
    input  logic [C+1+F:0]         quo,
    input  sic_pkg::sic_flags_t    flags,
    output logic                   hit_o,
    output logic signed [C-1:0]    cross_x_o,
    output logic signed [C-1:0]    cross_y_o
);
    localparam int QW = C + 2 + F;
    localparam int MW = QW + C + 1;
    localparam int SW = MW + 1;
    localparam int TW = SW - F;
    localparam int VW = TW + 1;
    localparam logic [QW-1:0] QMAX = QW'(1) << (C + 1 + F);

    logic signed [C-1:0]  ax1_reg, ay1_reg, ax2_reg, ay2_reg;
    logic signed [C:0]    bax1_reg, bay1_reg;
    logic [QW-1:0]        qmag1_reg;
    sic_pkg::sic_flags_t  flg1_reg, flg2_reg;
    logic signed [SW-1:0] px2_reg, py2_reg;

    function automatic logic signed [C-1:0] fit(input logic signed [C-1:0] a,
                                                input logic signed [SW-1:0] p);
        logic signed [SW-1:0] t;
        logic signed [TW-1:0] s;
        logic signed [VW-1:0] v;
        t = p + (SW'(1) <<< (F - 1));
        s = TW'(t >>> F);
        v = VW'(a) + VW'(s);
        if (v < -(VW'(1) <<< (C - 1)))
            fit = {1'b1, {(C-1){1'b0}}};
        else if (v > ((VW'(1) <<< (C - 1)) - VW'(1)))
            fit = {1'b0, {(C-1){1'b1}}};
        else
            fit = C'(v);
    endfunction

    function automatic logic signed [SW-1:0] scale(input logic [QW-1:0] q,
                                                   input logic signed [C:0] d,
                                                   input logic qneg);
        logic [C:0]    dm;
        logic [MW-1:0] m;
        dm = d[C] ? (C+1)'(-d) : (C+1)'(d);
        m  = MW'(q) * MW'(dm);
        scale = (qneg != d[C]) ? -SW'(m) : SW'(m);
    endfunction

    always_ff @(posedge aclk) begin
        if (en) begin
            ax1_reg   <= ax;
            ay1_reg   <= ay;
            bax1_reg  <= bax;
            bay1_reg  <= bay;
            flg1_reg  <= flags;
            qmag1_reg <= (flags.ovf || quo > QMAX) ? QMAX : quo;

            ax2_reg  <= ax1_reg;
            ay2_reg  <= ay1_reg;
            flg2_reg <= flg1_reg;
            px2_reg  <= scale(qmag1_reg, bax1_reg, flg1_reg.qneg);
            py2_reg  <= scale(qmag1_reg, bay1_reg, flg1_reg.qneg);

            hit_o     <= flg2_reg.hit && !flg2_reg.zero;
            cross_x_o <= flg2_reg.zero ? ax2_reg : fit(ax2_reg, px2_reg);
            cross_y_o <= flg2_reg.zero ? ay2_reg : fit(ay2_reg, py2_reg);
        end
    end

endmodule

@@ design/segment_intersection_core.sv @@
// Segment intersection core. Each input beat carries two segments, A-B and C-D, as eight
// signed fixed-point coordinates (Q12.4 at the default width); each output beat gives a hit
// flag and the point A + uA*(B-A), saturated to the coordinate range. A hit means both
// segment ratios lie in the closed range [0,1], tested exactly on the cross products.
// Parallel, collinear or zero-length input gives no hit and returns A. The core takes one
// beat per clock while no output beat is held; the pipe has four front-end stages, one
// divider stage per quotient bit and three back-end stages. The whole pipe advances
// together: it stalls only while an output beat waits on m_axis_tready, and bubbles
// travel down the pipe with it.
// Depends on sic_pkg, sic_prep, sic_div, sic_place and the assertion macro header.
`include "segment_intersection_core_macros.svh"

module segment_intersection_core #(
    parameter int COORD_BITS      = 16,
    parameter int RATIO_FRAC_BITS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // s_axis_tdata, low bit up: first_start_x, first_start_y, first_end_x, first_end_y,
    // second_start_x, second_start_y, second_end_x, second_end_y
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [8*COORD_BITS-1:0]        s_axis_tdata,
    // m_axis_tdata, low bit up: cross_x, cross_y, zero pad to whole bytes
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [((2*COORD_BITS+7)/8)*8-1:0] m_axis_tdata,
    // m_axis_tuser: hit
    output logic                           m_axis_tuser
);
    localparam int C   = COORD_BITS;
    localparam int F   = RATIO_FRAC_BITS;
    localparam int LAT = C + F + 9;
    localparam int OBW = ((2 * C + 7) / 8) * 8;

    logic                 en;
    logic [LAT-1:0]       vld_reg, vld_next;

    logic signed [C-1:0]  p_ax, p_ay, d_ax, d_ay;
    logic signed [C:0]    p_bax, p_bay, d_bax, d_bay;
    logic [2*C+2:0]       p_den;
    logic [2*C+3+F-1:0]   p_num;
    logic [C+1+F:0]       d_quo;
    sic_pkg::sic_flags_t  p_flags, d_flags;
    logic                 hit;
    logic signed [C-1:0]  cross_x, cross_y;

    // one enable for the whole pipe: move unless the output beat is held
    assign en            = !vld_reg[LAT-1] || m_axis_tready;
    assign s_axis_tready = en;

    always_comb begin
        vld_next = en ? {vld_reg[LAT-2:0], s_axis_tvalid} : vld_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    sic_prep #(.C(C), .F(F)) u_prep (
        .aclk    (aclk),
        .en      (en),
        .ax      (s_axis_tdata[C-1:0]),
        .ay      (s_axis_tdata[2*C-1:C]),
        .bx      (s_axis_tdata[3*C-1:2*C]),
        .by      (s_axis_tdata[4*C-1:3*C]),
        .cx      (s_axis_tdata[5*C-1:4*C]),
        .cy      (s_axis_tdata[6*C-1:5*C]),
        .dx      (s_axis_tdata[7*C-1:6*C]),
        .dy      (s_axis_tdata[8*C-1:7*C]),
        .ax_o    (p_ax),
        .ay_o    (p_ay),
        .bax_o   (p_bax),
        .bay_o   (p_bay),
        .den_o   (p_den),
        .num_o   (p_num),
        .flags_o (p_flags)
    );

    sic_div #(.C(C), .F(F)) u_div (
        .aclk    (aclk),
        .en      (en),
        .ax      (p_ax),
        .ay      (p_ay),
        .bax     (p_bax),
        .bay     (p_bay),
        .den     (p_den),
        .num     (p_num),
        .flags   (p_flags),
        .ax_o    (d_ax),
        .ay_o    (d_ay),
        .bax_o   (d_bax),
        .bay_o   (d_bay),
        .quo_o   (d_quo),
        .flags_o (d_flags)
    );

    sic_place #(.C(C), .F(F)) u_place (
        .aclk      (aclk),
        .en        (en),
        .ax        (d_ax),
        .ay        (d_ay),
        .bax       (d_bax),
        .bay       (d_bay),
        .quo       (d_quo),
        .flags     (d_flags),
        .hit_o     (hit),
        .cross_x_o (cross_x),
        .cross_y_o (cross_y)
    );

    assign m_axis_tvalid = vld_reg[LAT-1];
    assign m_axis_tuser  = hit;
    assign m_axis_tdata  = OBW'({cross_y, cross_x});

    // pipe is empty straight after reset
    `SIC_ASSERT_ALWAYS(a_rst_empty, !aresetn |=> (vld_reg == '0), "pipe not empty after reset")
    // a held output beat freezes every stage's valid bit
    `SIC_ASSERT(a_stall_freeze, !en |=> $stable(vld_reg), "valid bits moved during stall")
    // a waiting output beat keeps its payload
    `SIC_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "output beat changed while held")

endmodule

@@ tb/sv/tb.sv @@
// Testbench for segment_intersection_core: streams segment pairs, predicts hit flag
// and crossing point with an exact fixed-point model, checks every output beat.
// Depends on the RTL of segment_intersection_core only.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB = 16;
    localparam int RF = 16;
    localparam int OW = ((2*CB+7)/8)*8;
    localparam int LATENCY = CB + RF + 9;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [CB-1:0] dy, dx, cy, cx, by, bx, ay, ax;
    } seg_pair_t;

    typedef struct packed {
        logic          hit;
        logic [CB-1:0] cross_x;
        logic [CB-1:0] cross_y;
    } crossing_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [8*CB-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OW-1:0] m_axis_tdata;
    logic m_axis_tuser;

    seg_pair_t pending_pairs[$];
    crossing_t expected_crossings[$];
    int mismatches = 0;
    int beats_in = 0;
    int beats_out = 0;
    int hits_seen = 0;
    int idle_cycles = 0;
    int send_gap = 0;
    int recv_gap = 0;
    bit stimulus_done = 1'b0;
    bit s_taken = 1'b0;

    segment_intersection_core #(.COORD_BITS(CB), .RATIO_FRAC_BITS(RF)) u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // mostly short gaps, now and then a long one, often none
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // one coordinate as a + delta * (Q.RF ratio) with round half up, then saturated
    function automatic logic [CB-1:0] place_coord(longint a, longint delta, logic signed [127:0] q);
        logic signed [127:0] p;
        longint v;
        p = q * delta;
        p = (p + (128'sd1 <<< (RF-1))) >>> RF;
        v = a + longint'(p);
        if (v < -(64'sd1 <<< (CB-1))) v = -(64'sd1 <<< (CB-1));
        if (v > (64'sd1 <<< (CB-1)) - 1) v = (64'sd1 <<< (CB-1)) - 1;
        return v[CB-1:0];
    endfunction

    function automatic crossing_t predict_crossing(seg_pair_t s);
        longint ax, ay, bx, by, cx, cy, dx, dy, bax, bay, dcx, dcy, acx, acy;
        logic signed [127:0] den, na, nb, q, qmax, mag;
        crossing_t r;
        ax = longint'($signed(s.ax)); ay = longint'($signed(s.ay));
        bx = longint'($signed(s.bx)); by = longint'($signed(s.by));
        cx = longint'($signed(s.cx)); cy = longint'($signed(s.cy));
        dx = longint'($signed(s.dx)); dy = longint'($signed(s.dy));
        bax = bx - ax; bay = by - ay; dcx = dx - cx; dcy = dy - cy;
        acx = ax - cx; acy = ay - cy;
        den = 128'(dcy) * 128'(bax) - 128'(dcx) * 128'(bay);
        na  = 128'(dcx) * 128'(acy) - 128'(dcy) * 128'(acx);
        nb  = 128'(bax) * 128'(acy) - 128'(bay) * 128'(acx);
        if (den == 0) begin
            r.hit = 1'b0;
            r.cross_x = s.ax;
            r.cross_y = s.ay;
            return r;
        end
        if (den < 0) begin
            den = -den; na = -na; nb = -nb;
        end
        r.hit = (na >= 0) && (na <= den) && (nb >= 0) && (nb <= den);
        // quotient truncated toward zero, magnitude clamped
        mag = ((na < 0 ? -na : na) <<< RF) / den;
        qmax = 128'sd1 <<< (CB + 1 + RF);
        if (mag > qmax) mag = qmax;
        q = (na < 0) ? -mag : mag;
        r.cross_x = place_coord(ax, bax, q);
        r.cross_y = place_coord(ay, bay, q);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [CB-1:0] got, logic [CB-1:0] want);
        mismatches++;
        $display("mismatch on beat %0d: %s got %h want %h", beats_out, what, got, want);
    endtask

    function automatic logic [CB-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return {1'b1, {(CB-1){1'b0}}};
            1: return {1'b0, {(CB-1){1'b1}}};
            2: return CB'($urandom_range(0, 64)) - CB'(32);
            default: return CB'($urandom);
        endcase
    endfunction

    function automatic seg_pair_t make_pair(logic [CB-1:0] ax, logic [CB-1:0] ay,
                                            logic [CB-1:0] bx, logic [CB-1:0] by,
                                            logic [CB-1:0] cx, logic [CB-1:0] cy,
                                            logic [CB-1:0] dx, logic [CB-1:0] dy);
        seg_pair_t s;
        s.ax = ax; s.ay = ay; s.bx = bx; s.by = by;
        s.cx = cx; s.cy = cy; s.dx = dx; s.dy = dy;
        return s;
    endfunction

    // stimulus
    initial begin
        logic [CB-1:0] mn, mx;
        seg_pair_t s;
        int k;
        mn = {1'b1, {(CB-1){1'b0}}};
        mx = {1'b0, {(CB-1){1'b1}}};
        // plain crossing, X shape
        pending_pairs.push_back(make_pair(0, 0, 16'd160, 16'd160, 0, 16'd160, 16'd160, 0));
        // parallel lines
        pending_pairs.push_back(make_pair(0, 0, 16'd160, 0, 0, 16'd32, 16'd160, 16'd32));
        // collinear overlap
        pending_pairs.push_back(make_pair(0, 0, 16'd100, 0, 16'd50, 0, 16'd200, 0));
        // zero-length segments
        pending_pairs.push_back(make_pair(16'd5, 16'd7, 16'd5, 16'd7, 0, 0, 16'd30, 16'd9));
        pending_pairs.push_back(make_pair(0, 0, 16'd30, 16'd9, 16'd5, 16'd7, 16'd5, 16'd7));
        // touching at an endpoint: ratio exactly 0 and exactly 1
        pending_pairs.push_back(make_pair(0, 0, 16'd64, 0, 0, 0, 0, 16'd64));
        pending_pairs.push_back(make_pair(0, 0, 16'd64, 0, 16'd64, -16'sd10, 16'd64, 16'd10));
        // lines cross outside the segments, negative and huge ratios
        pending_pairs.push_back(make_pair(0, 0, 16'd1, 0, 16'd500, -16'sd5, 16'd500, 16'd5));
        pending_pairs.push_back(make_pair(0, 0, 16'd1, 0, -16'sd500, -16'sd5, -16'sd500, 16'd5));
        pending_pairs.push_back(make_pair(mx, mx, mn, mn, mn, mx, mx, mn));
        pending_pairs.push_back(make_pair(mn, mn, mx, mx, mn, mx, mx, mn));
        pending_pairs.push_back(make_pair(mn, mn, mn, mx, mx, mn, mx, mx));
        pending_pairs.push_back(make_pair(0, 0, 16'd1, 16'd1, mx, mn, mx, mn + 16'd1));
        pending_pairs.push_back(make_pair(mn, mx, mn + 16'd1, mx, 0, mn, 16'd1, mx));
        pending_pairs.push_back(make_pair('1, '1, 0, 0, '1, 0, 0, '1));
        pending_pairs.push_back(make_pair(mx, mn, mn, mx, mx, mx, mn, mn));
        // random: mostly pairs built around the first segment's midpoint, some parallel, rest noise
        for (k = 0; k < 650; k++) begin
            if ($urandom_range(0, 99) < 60) begin
                s.ax = rand_coord(); s.ay = rand_coord();
                s.bx = rand_coord(); s.by = rand_coord();
                // second segment from up-left to down-right of the midpoint of the first
                s.cx = CB'(($signed(s.ax) + $signed(s.bx)) >>> 1) - CB'($urandom_range(0, 400));
                s.cy = CB'(($signed(s.ay) + $signed(s.by)) >>> 1) + CB'($urandom_range(0, 400));
                s.dx = CB'(($signed(s.ax) + $signed(s.bx)) >>> 1) + CB'($urandom_range(0, 400));
                s.dy = CB'(($signed(s.ay) + $signed(s.by)) >>> 1) - CB'($urandom_range(0, 400));
            end else if ($urandom_range(0, 9) == 0) begin
                // parallel by construction
                s.ax = rand_coord(); s.ay = rand_coord();
                s.bx = s.ax + CB'($urandom_range(0, 50));
                s.by = s.ay + CB'($urandom_range(0, 50));
                s.cx = rand_coord(); s.cy = rand_coord();
                s.dx = s.cx + (s.bx - s.ax); s.dy = s.cy + (s.by - s.ay);
            end else begin
                s = {$urandom, $urandom, $urandom, $urandom};
            end
            pending_pairs.push_back(s);
        end
        stimulus_done = 1'b1;
    end

    // reset, then end of run
    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;
        wait (stimulus_done && pending_pairs.size() == 0 && !s_axis_tvalid
              && expected_crossings.size() == 0);
        repeat (2 * LATENCY) @(posedge aclk);
        $display("%0d segment pairs sent, %0d results checked, %0d hits among them",
                 beats_in, beats_out, hits_seen);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // driver: present a beat once the gap has run out
    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_axis_tvalid && !s_taken) begin
                // hold the beat
            end else if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (pending_pairs.size() > 0) begin
                s_axis_tdata <= pending_pairs.pop_front();
                s_axis_tvalid <= 1'b1;
                send_gap <= pick_gap();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
            if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if (m_axis_tready) recv_gap <= pick_gap();
            end
        end
    end

    // monitor: predict on input beats, check on output beats
    always @(posedge aclk) begin
        crossing_t want;
        if (aresetn) begin
            s_taken <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready) begin
                expected_crossings.push_back(predict_crossing(s_axis_tdata));
                beats_in <= beats_in + 1;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                beats_out <= beats_out + 1;
                if (expected_crossings.size() == 0) begin
                    report_mismatch("unexpected beat", CB'(m_axis_tuser), '0);
                end else begin
                    want = expected_crossings.pop_front();
                    if (m_axis_tuser) hits_seen <= hits_seen + 1;
                    if (m_axis_tuser !== want.hit)
                        report_mismatch("hit", CB'(m_axis_tuser), CB'(want.hit));
                    if (m_axis_tdata[CB-1:0] !== want.cross_x)
                        report_mismatch("cross_x", m_axis_tdata[CB-1:0], want.cross_x);
                    if (m_axis_tdata[2*CB-1:CB] !== want.cross_y)
                        report_mismatch("cross_y", m_axis_tdata[2*CB-1:CB], want.cross_y);
                end
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("FAILURE");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end
endmodule
